[hdl/m2x2_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// m2x2_pkg
// Types, operation codes and shared arithmetic for the 2x2 matrix unit.
// ----------------------------------------------------------------------------
package m2x2_pkg;

   localparam int ELEM_W  = 32;
   localparam int NUM_W   = ELEM_W + 1;
   localparam int PROD_W  = 2 * ELEM_W;
   localparam int SUM_W   = PROD_W + 2;
   localparam int DIV_W   = 64;
   localparam int QB      = 33;
   localparam int DIV_LAT = QB + 2;
   localparam int ASUM_W  = ELEM_W + 2;
   localparam int CFG_W   = 31;
   localparam int CSR_IW  = 2;

   localparam logic [3:0] OP_ADD   = 4'd0;
   localparam logic [3:0] OP_SUB   = 4'd1;
   localparam logic [3:0] OP_MUL   = 4'd2;
   localparam logic [3:0] OP_AINVB = 4'd3;
   localparam logic [3:0] OP_INV   = 4'd4;
   localparam logic [3:0] OP_ADDS  = 4'd5;
   localparam logic [3:0] OP_SUBS  = 4'd6;
   localparam logic [3:0] OP_MULS  = 4'd7;
   localparam logic [3:0] OP_DIVS  = 4'd8;
   localparam logic [3:0] OP_SSUB  = 4'd9;
   localparam logic [3:0] OP_SINV  = 4'd10;
   localparam logic [3:0] OP_ABS   = 4'd11;
   localparam logic [3:0] OP_NEG   = 4'd12;
   localparam logic [3:0] OP_CMP   = 4'd13;
   localparam logic [3:0] OP_MAX   = 4'd14;

   localparam logic [1:0] STAT_OK   = 2'd0;
   localparam logic [1:0] STAT_SING = 2'd1;
   localparam logic [1:0] STAT_DIV0 = 2'd2;
   localparam logic [1:0] STAT_SAT  = 2'd3;

   localparam logic [1:0] CMP_LESS    = 2'd0;
   localparam logic [1:0] CMP_EQUAL   = 2'd1;
   localparam logic [1:0] CMP_GREATER = 2'd2;

   localparam logic [CSR_IW-1:0] CSR_DET_THR = 2'd0;
   localparam logic [CSR_IW-1:0] CSR_EQ_TOL  = 2'd1;

   // Matrix product operand indices per lane, and inverse numerator sources.
   localparam logic [1:0] MM_X1 [4] = '{2'd0, 2'd0, 2'd3, 2'd3};
   localparam logic [1:0] MM_Y1 [4] = '{2'd0, 2'd1, 2'd1, 2'd0};
   localparam logic [1:0] MM_X2 [4] = '{2'd1, 2'd1, 2'd2, 2'd2};
   localparam logic [1:0] MM_Y2 [4] = '{2'd3, 2'd2, 2'd2, 2'd3};
   localparam logic [1:0] INV_SRC [4] = '{2'd2, 2'd1, 2'd0, 2'd3};
   localparam logic       INV_NEG [4] = '{1'b0, 1'b1, 1'b0, 1'b1};

   typedef logic [3:0][ELEM_W-1:0] quad_type;

   typedef struct packed {
      logic signed [ELEM_W-1:0] val;
      logic                     sat;
   } res_type;

   typedef struct packed {
      logic stage_a;
      logic stage_b;
   } mul_en_type;

   typedef struct packed {
      logic [3:0]        op;
      quad_type          a;
      quad_type          b;
      logic [ELEM_W-1:0] s;
      quad_type          simp;
      logic              simp_sat;
      logic [ASUM_W-1:0] sa;
      logic [ASUM_W-1:0] sb;
      logic [1:0]        cmp;
      logic              sing;
      quad_type          t;
      logic              tsat;
   } pl_type;

   function automatic res_type sat32(input logic signed [SUM_W-1:0] v);
      res_type r;
      r.sat = !((&v[SUM_W-1:ELEM_W-1]) || !(|v[SUM_W-1:ELEM_W-1]));
      if (r.sat) begin
         r.val = v[SUM_W-1] ? {1'b1, {(ELEM_W-1){1'b0}}} : {1'b0, {(ELEM_W-1){1'b1}}};
      end else begin
         r.val = v[ELEM_W-1:0];
      end
      return r;
   endfunction

   function automatic res_type simple_op(input logic [3:0] op,
                                         input logic signed [ELEM_W-1:0] a,
                                         input logic signed [ELEM_W-1:0] b,
                                         input logic signed [ELEM_W-1:0] s);
      logic signed [NUM_W-1:0] v;
      case (op)
         OP_ADD:  v = NUM_W'(a) + NUM_W'(b);
         OP_SUB:  v = NUM_W'(a) - NUM_W'(b);
         OP_ADDS: v = NUM_W'(a) + NUM_W'(s);
         OP_SUBS: v = NUM_W'(a) - NUM_W'(s);
         OP_SSUB: v = NUM_W'(s) - NUM_W'(a);
         OP_ABS:  v = a[ELEM_W-1] ? -NUM_W'(a) : NUM_W'(a);
         OP_NEG:  v = -NUM_W'(a);
         default: v = '0;
      endcase
      return sat32(SUM_W'(v));
   endfunction

   function automatic logic [ASUM_W-1:0] abs_sum(input quad_type q);
      logic [ASUM_W-1:0] acc;
      logic [ELEM_W-1:0] m;
      acc = '0;
      for (int i = 0; i < 4; i++) begin
         m = q[i][ELEM_W-1] ? (~q[i] + 1'b1) : q[i];
         acc = acc + ASUM_W'(m);
      end
      return acc;
   endfunction

endpackage
`default_nettype wire

[hdl/m2x2_mul_lane.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// m2x2_mul_lane
// Two signed products, summed or differenced, rounded and saturated.
// ----------------------------------------------------------------------------
module m2x2_mul_lane
   import m2x2_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  wire                     clock,
   input  mul_en_type              en,
   input  wire signed [ELEM_W-1:0] x1,
   input  wire signed [ELEM_W-1:0] y1,
   input  wire signed [ELEM_W-1:0] x2,
   input  wire signed [ELEM_W-1:0] y2,
   input  wire                     sub,
   output logic signed [SUM_W-1:0] raw,
   output res_type                 res
);

   localparam logic signed [SUM_W-1:0] HALF = SUM_W'(1) <<< (FRAC_BITS - 1);

   logic signed [PROD_W-1:0] p_ff, q_ff;
   logic                     sub_ff;
   logic signed [SUM_W-1:0]  sum, shr;

   always_ff @(posedge clock) begin
      if (en.stage_a) begin
         p_ff   <= x1 * y1;
         q_ff   <= x2 * y2;
         sub_ff <= sub;
      end
   end

   always_comb begin
      sum = sub_ff ? (SUM_W'(p_ff) - SUM_W'(q_ff)) : (SUM_W'(p_ff) + SUM_W'(q_ff));
      shr = (sum + HALF) >>> FRAC_BITS;
   end

   always_ff @(posedge clock) begin
      if (en.stage_b) begin
         raw <= shr;
         res <= sat32(shr);
      end
   end

endmodule
`default_nettype wire

[hdl/m2x2_div_lane.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// m2x2_div_lane
// Pipelined restoring divider: rounded fixed-point quotient, one bit a stage.
// ----------------------------------------------------------------------------
module m2x2_div_lane
   import m2x2_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  wire                     clock,
   input  wire                     en,
   input  wire signed [NUM_W-1:0]  num,
   input  wire signed [SUM_W-1:0]  den,
   output res_type                 res
);

   logic [DIV_W-1:0] rem_ff [QB+1];
   logic [DIV_W-1:0] dvs_ff [QB+1];
   logic [QB-1:0]    quo_ff [QB+1];
   logic             neg_ff [QB+1];
   logic             ovf_ff [QB+1];

   logic [NUM_W-1:0] num_mag;
   logic [SUM_W-1:0] den_mag;
   logic [DIV_W-1:0] un, ud;

   always_comb begin
      num_mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
      den_mag = den[SUM_W-1] ? SUM_W'(-den) : SUM_W'(den);
      un      = DIV_W'(num_mag) << FRAC_BITS;
      ud      = den_mag[DIV_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= (un << 1) + ud;
         dvs_ff[0] <= ud << 1;
         quo_ff[0] <= '0;
         neg_ff[0] <= num[NUM_W-1] ^ den[SUM_W-1];
         ovf_ff[0] <= 1'b0;
      end
   end

   for (genvar j = 1; j <= QB; j++) begin : g_bit
      localparam int K = QB - j;
      logic fit, big;
      assign fit = (rem_ff[j-1] >> K) >= dvs_ff[j-1];
      assign big = (j == 1) && ((rem_ff[j-1] >> QB) >= dvs_ff[j-1]);
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[j] <= fit ? (rem_ff[j-1] - (dvs_ff[j-1] << K)) : rem_ff[j-1];
            dvs_ff[j] <= dvs_ff[j-1];
            quo_ff[j] <= {quo_ff[j-1][QB-2:0], fit};
            neg_ff[j] <= neg_ff[j-1];
            ovf_ff[j] <= ovf_ff[j-1] | big;
         end
      end
   end

   logic    too_big;
   res_type res_in;

   always_comb begin
      too_big = ovf_ff[QB]
              || (!neg_ff[QB] && (quo_ff[QB] > QB'({1'b0, {(ELEM_W-1){1'b1}}})))
              || (neg_ff[QB] && (quo_ff[QB] > QB'({1'b1, {(ELEM_W-1){1'b0}}})));
      res_in.sat = too_big;
      if (too_big) begin
         res_in.val = neg_ff[QB] ? {1'b1, {(ELEM_W-1){1'b0}}} : {1'b0, {(ELEM_W-1){1'b1}}};
      end else begin
         res_in.val = neg_ff[QB] ? -quo_ff[QB][ELEM_W-1:0] : quo_ff[QB][ELEM_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         res <= res_in;
      end
   end

endmodule
`default_nettype wire

[hdl/matrix2x2_arith_unit_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// matrix2x2_arith_unit_top
// 2x2 matrix arithmetic unit on signed fixed-point elements, four lanes.
//
//   Channel  Direction  Handshake              Carries
//   req      in         req_valid/req_ready    opcode, matrices A and B, scalar
//   rsp      out        rsp_valid/rsp_ready    four elements, status, compare code
//   csr      in         csr_valid/csr_ready    register index and data
//
// One item per cycle is sustained while results are taken; the depth of the
// pipeline is set by the bit-per-stage dividers in the four division lanes.
// Reset clears all valid flags and loads the register defaults.
// A result not taken stalls the whole pipeline; the first stage still takes
// an item while it is empty.
// ----------------------------------------------------------------------------
module matrix2x2_arith_unit_top
   import m2x2_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_valid,
   output logic                     req_ready,
   input  wire        [3:0]         req_type,
   input  wire signed [ELEM_W-1:0]  req_a_e1,
   input  wire signed [ELEM_W-1:0]  req_a_e2,
   input  wire signed [ELEM_W-1:0]  req_a_e3,
   input  wire signed [ELEM_W-1:0]  req_a_e4,
   input  wire signed [ELEM_W-1:0]  req_b_e1,
   input  wire signed [ELEM_W-1:0]  req_b_e2,
   input  wire signed [ELEM_W-1:0]  req_b_e3,
   input  wire signed [ELEM_W-1:0]  req_b_e4,
   input  wire signed [ELEM_W-1:0]  req_scalar_val,
   output logic                     rsp_valid,
   input  wire                      rsp_ready,
   output logic signed [ELEM_W-1:0] rsp_r_e1,
   output logic signed [ELEM_W-1:0] rsp_r_e2,
   output logic signed [ELEM_W-1:0] rsp_r_e3,
   output logic signed [ELEM_W-1:0] rsp_r_e4,
   output logic       [1:0]         rsp_status,
   output logic       [1:0]         rsp_cmp_code,
   input  wire                      csr_valid,
   output logic                     csr_ready,
   input  wire        [CSR_IW-1:0]  csr_index,
   input  wire        [CFG_W-1:0]   csr_data
);

   logic [CFG_W-1:0] det_thr_ff, eq_tol_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         det_thr_ff <= CFG_W'(1);
         eq_tol_ff  <= CFG_W'(655);
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_DET_THR: det_thr_ff <= csr_data;
            CSR_EQ_TOL:  eq_tol_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   logic adv, ld1;
   logic v1_ff, v2_ff, mv1_ff, mv2_ff;
   logic [DIV_LAT-1:0] dv_ff;

   assign adv       = !rsp_valid || rsp_ready;
   assign ld1       = adv || !v1_ff;
   assign req_ready = ld1;

   // Front stage: simple element ops, max, absolute sums, determinant products.
   quad_type   a_in, b_in, xq_in;
   pl_type     p1_in, p1_ff, p2_in, p2_ff;
   res_type    sr;
   logic signed [ELEM_W-1:0] mx;
   mul_en_type det_en;
   logic signed [SUM_W-1:0] det_raw;

   always_comb begin
      a_in  = {req_a_e4, req_a_e3, req_a_e2, req_a_e1};
      b_in  = {req_b_e4, req_b_e3, req_b_e2, req_b_e1};
      xq_in = (req_type == OP_AINVB) ? b_in : a_in;
      p1_in = '0;
      p1_in.op = req_type;
      p1_in.a  = a_in;
      p1_in.b  = b_in;
      p1_in.s  = req_scalar_val;
      for (int i = 0; i < 4; i++) begin
         sr = simple_op(req_type, $signed(a_in[i]), $signed(b_in[i]), req_scalar_val);
         p1_in.simp[i] = sr.val;
         p1_in.simp_sat = p1_in.simp_sat | sr.sat;
      end
      mx = req_a_e1;
      if (req_a_e2 > mx) mx = req_a_e2;
      if (req_a_e3 > mx) mx = req_a_e3;
      if (req_a_e4 > mx) mx = req_a_e4;
      if (req_type == OP_MAX) begin
         p1_in.simp[0] = mx;
      end
      p1_in.sa = abs_sum(a_in);
      p1_in.sb = abs_sum(b_in);
   end

   assign det_en.stage_a = ld1;
   assign det_en.stage_b = adv;

   m2x2_mul_lane #(.FRAC_BITS(FRAC_BITS)) u_det (
      .clock (clock),
      .en    (det_en),
      .x1    ($signed(xq_in[0])),
      .y1    ($signed(xq_in[2])),
      .x2    ($signed(xq_in[1])),
      .y2    ($signed(xq_in[3])),
      .sub   (1'b1),
      .raw   (det_raw),
      .res   ()
   );

   logic signed [ASUM_W:0] sdiff;
   logic [ASUM_W:0]        sdiff_mag;

   always_comb begin
      p2_in     = p1_ff;
      sdiff     = $signed({1'b0, p1_ff.sa}) - $signed({1'b0, p1_ff.sb});
      sdiff_mag = sdiff[ASUM_W] ? (ASUM_W+1)'(-sdiff) : (ASUM_W+1)'(sdiff);
      if (p1_ff.op != OP_CMP) begin
         p2_in.cmp = CMP_LESS;
      end else if (sdiff_mag < (ASUM_W+1)'(eq_tol_ff)) begin
         p2_in.cmp = CMP_EQUAL;
      end else if (p1_ff.sa < p1_ff.sb) begin
         p2_in.cmp = CMP_LESS;
      end else begin
         p2_in.cmp = CMP_GREATER;
      end
   end

   always_ff @(posedge clock) begin
      if (ld1) p1_ff <= p1_in;
      if (adv) p2_ff <= p2_in;
   end

   // Division lanes: inverse elements over the determinant, or A over the scalar.
   quad_type                 xq2;
   logic                     inv_op;
   logic [SUM_W-1:0]         det_mag;
   logic signed [NUM_W-1:0]  dnum [4];
   logic signed [SUM_W-1:0]  dden [4];
   res_type                  dres [4];
   pl_type                   d0_in;
   pl_type                   dl_ff [DIV_LAT];

   always_comb begin
      xq2     = (p2_ff.op == OP_AINVB) ? p2_ff.b : p2_ff.a;
      inv_op  = (p2_ff.op == OP_AINVB) || (p2_ff.op == OP_INV) || (p2_ff.op == OP_SINV);
      det_mag = det_raw[SUM_W-1] ? SUM_W'(-det_raw) : SUM_W'(det_raw);
      d0_in   = p2_ff;
      d0_in.sing = (det_raw == '0) || (det_mag < SUM_W'(det_thr_ff));
      for (int i = 0; i < 4; i++) begin
         if (inv_op) begin
            dnum[i] = INV_NEG[i] ? -NUM_W'($signed(xq2[INV_SRC[i]]))
                                 : NUM_W'($signed(xq2[INV_SRC[i]]));
            dden[i] = det_raw;
         end else begin
            dnum[i] = NUM_W'($signed(p2_ff.a[i]));
            dden[i] = SUM_W'($signed(p2_ff.s));
         end
      end
   end

   for (genvar i = 0; i < 4; i++) begin : g_div
      m2x2_div_lane #(.FRAC_BITS(FRAC_BITS)) u_div (
         .clock (clock),
         .en    (adv),
         .num   (dnum[i]),
         .den   (dden[i]),
         .res   (dres[i])
      );
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dl_ff[0] <= d0_in;
         for (int j = 1; j < DIV_LAT; j++) begin
            dl_ff[j] <= dl_ff[j-1];
         end
      end
   end

   // Product lanes: matrix products, scalar products, products with an inverse.
   pl_type     pd, m1_in, m1_ff, m2_ff;
   quad_type   tq, ysrc;
   logic signed [ELEM_W-1:0] mx1 [4], my1 [4], mx2 [4], my2 [4];
   res_type    mres [4];
   mul_en_type back_en;

   assign back_en.stage_a = adv;
   assign back_en.stage_b = adv;

   always_comb begin
      pd = dl_ff[DIV_LAT-1];
      for (int i = 0; i < 4; i++) begin
         tq[i] = dres[i].val;
      end
      ysrc = (pd.op == OP_AINVB) ? tq : pd.b;
      for (int i = 0; i < 4; i++) begin
         if (pd.op == OP_MULS) begin
            mx1[i] = $signed(pd.a[i]);
            my1[i] = $signed(pd.s);
            mx2[i] = '0;
            my2[i] = '0;
         end else if (pd.op == OP_SINV) begin
            mx1[i] = $signed(pd.s);
            my1[i] = $signed(tq[i]);
            mx2[i] = '0;
            my2[i] = '0;
         end else begin
            mx1[i] = $signed(pd.a[MM_X1[i]]);
            my1[i] = $signed(ysrc[MM_Y1[i]]);
            mx2[i] = $signed(pd.a[MM_X2[i]]);
            my2[i] = $signed(ysrc[MM_Y2[i]]);
         end
      end
      m1_in      = pd;
      m1_in.t    = tq;
      m1_in.tsat = dres[0].sat | dres[1].sat | dres[2].sat | dres[3].sat;
   end

   for (genvar i = 0; i < 4; i++) begin : g_mul
      m2x2_mul_lane #(.FRAC_BITS(FRAC_BITS)) u_mul (
         .clock (clock),
         .en    (back_en),
         .x1    (mx1[i]),
         .y1    (my1[i]),
         .x2    (mx2[i]),
         .y2    (my2[i]),
         .sub   (1'b0),
         .raw   (),
         .res   (mres[i])
      );
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         m1_ff <= m1_in;
         m2_ff <= m1_ff;
      end
   end

   // Merge: pick the lane results for the opcode and form the status.
   quad_type   r_in;
   logic [1:0] err_in, cmp_in;
   logic       sat_in, msat;

   always_comb begin
      msat   = mres[0].sat | mres[1].sat | mres[2].sat | mres[3].sat;
      r_in   = '0;
      err_in = STAT_OK;
      sat_in = 1'b0;
      cmp_in = m2_ff.cmp;
      case (m2_ff.op)
         OP_ADD, OP_SUB, OP_ADDS, OP_SUBS, OP_SSUB, OP_ABS, OP_NEG, OP_MAX: begin
            r_in   = m2_ff.simp;
            sat_in = m2_ff.simp_sat;
         end
         OP_MUL, OP_MULS: begin
            for (int i = 0; i < 4; i++) r_in[i] = mres[i].val;
            sat_in = msat;
         end
         OP_AINVB, OP_SINV: begin
            if (m2_ff.sing) begin
               err_in = STAT_SING;
            end else begin
               for (int i = 0; i < 4; i++) r_in[i] = mres[i].val;
               sat_in = msat | m2_ff.tsat;
            end
         end
         OP_INV: begin
            if (m2_ff.sing) begin
               err_in = STAT_SING;
            end else begin
               r_in   = m2_ff.t;
               sat_in = m2_ff.tsat;
            end
         end
         OP_DIVS: begin
            if (m2_ff.s == '0) begin
               err_in = STAT_DIV0;
            end else begin
               r_in   = m2_ff.t;
               sat_in = m2_ff.tsat;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_r_e1     <= r_in[0];
         rsp_r_e2     <= r_in[1];
         rsp_r_e3     <= r_in[2];
         rsp_r_e4     <= r_in[3];
         rsp_status   <= (err_in != STAT_OK) ? err_in : (sat_in ? STAT_SAT : STAT_OK);
         rsp_cmp_code <= cmp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff     <= 1'b0;
         v2_ff     <= 1'b0;
         dv_ff     <= '0;
         mv1_ff    <= 1'b0;
         mv2_ff    <= 1'b0;
         rsp_valid <= 1'b0;
      end else begin
         if (ld1) v1_ff <= req_valid;
         if (adv) begin
            v2_ff     <= v1_ff;
            dv_ff     <= {dv_ff[DIV_LAT-2:0], v2_ff};
            mv1_ff    <= dv_ff[DIV_LAT-1];
            mv2_ff    <= mv1_ff;
            rsp_valid <= mv2_ff;
         end
      end
   end

endmodule
`default_nettype wire

[verif/matrix2x2_arith_unit_top_test.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// matrix2x2_arith_unit_top_test
// Self-checking testbench for the 2x2 fixed-point matrix arithmetic unit. A
// short table of directed items is followed by random items under several
// register settings. Each result is checked against a table value or an
// independent fixed-point predictor; both handshakes are throttled at random.
// ----------------------------------------------------------------------------
module matrix2x2_arith_unit_top_test;
   import m2x2_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAC = 16;
   localparam int SETTLE_CYCLES = DIV_LAT + 20;
   localparam logic [CSR_IW-1:0] CSR_UNUSED = 2'd3;
   localparam logic [3:0] OP_NONE = 4'd15;

   typedef logic signed [ELEM_W-1:0] elem_type;
   typedef logic signed [65:0] wide_type;

   localparam elem_type MAXV = 32'sh7FFF_FFFF;
   localparam elem_type MINV = 32'sh8000_0000;
   localparam elem_type ONE = 32'sh0001_0000;

   typedef struct {
      logic [3:0] op;
      elem_type   a [4];
      elem_type   b [4];
      elem_type   s;
   } mat_item_type;

   typedef struct {
      elem_type   r [4];
      logic [1:0] status;
      logic [1:0] cmp;
   } mat_rsp_type;

   typedef struct {
      mat_item_type it;
      bit           known;
      mat_rsp_type  exp;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [3:0] req_type = '0;
   elem_type req_a_e1 = '0, req_a_e2 = '0, req_a_e3 = '0, req_a_e4 = '0;
   elem_type req_b_e1 = '0, req_b_e2 = '0, req_b_e3 = '0, req_b_e4 = '0;
   elem_type req_scalar_val = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   elem_type rsp_r_e1, rsp_r_e2, rsp_r_e3, rsp_r_e4;
   logic [1:0] rsp_status, rsp_cmp_code;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IW-1:0] csr_index = '0;
   logic [CFG_W-1:0] csr_data = '0;

   logic [CFG_W-1:0] det_thr = 31'd1;
   logic [CFG_W-1:0] eq_tol = 31'd655;

   mat_rsp_type pending_rsp [$];
   dir_row_type dir_tab [$];
   int errors = 0;
   int items_sent = 0;
   int rsp_seen = 0;
   int op_count [16];
   int stall_mode = 0;
   int cyc = 0;

   matrix2x2_arith_unit_top #(.FRAC_BITS(FRAC)) i_dut (
      .clock, .reset, .req_valid, .req_ready, .req_type,
      .req_a_e1, .req_a_e2, .req_a_e3, .req_a_e4,
      .req_b_e1, .req_b_e2, .req_b_e3, .req_b_e4, .req_scalar_val,
      .rsp_valid, .rsp_ready, .rsp_r_e1, .rsp_r_e2, .rsp_r_e3, .rsp_r_e4,
      .rsp_status, .rsp_cmp_code, .csr_valid, .csr_ready, .csr_index, .csr_data
   );

   always #5 clock = ~clock;

   function automatic elem_type clip(input wide_type v, inout bit sat);
      if (v > wide_type'(MAXV)) begin
         sat = 1'b1;
         return MAXV;
      end
      if (v < wide_type'(MINV)) begin
         sat = 1'b1;
         return MINV;
      end
      return elem_type'(v);
   endfunction

   function automatic wide_type round_prod(input wide_type p);
      return (p + (wide_type'(1) <<< (FRAC - 1))) >>> FRAC;
   endfunction

   function automatic elem_type fx_div(input wide_type n, input wide_type d, inout bit sat);
      logic [65:0] un, ud, q;
      wide_type r;
      un = (n < 0 ? -n : n) << FRAC;
      ud = d < 0 ? -d : d;
      q = (2 * un + ud) / (2 * ud);
      r = q;
      if ((n < 0) != (d < 0))
         r = -r;
      return clip(r, sat);
   endfunction

   function automatic bit invert(input elem_type m [4], output elem_type r [4],
                                 inout bit sat);
      wide_type det;
      logic [65:0] mag;
      det = round_prod(wide_type'(m[0]) * wide_type'(m[2])
                       - wide_type'(m[1]) * wide_type'(m[3]));
      mag = det < 0 ? -det : det;
      r = '{0, 0, 0, 0};
      if (det == 0 || mag < 66'(det_thr))
         return 1'b0;
      r[0] = fx_div(wide_type'(m[2]), det, sat);
      r[1] = fx_div(-wide_type'(m[1]), det, sat);
      r[2] = fx_div(wide_type'(m[0]), det, sat);
      r[3] = fx_div(-wide_type'(m[3]), det, sat);
      return 1'b1;
   endfunction

   function automatic wide_type prod(input elem_type x, input elem_type y);
      return wide_type'(x) * wide_type'(y);
   endfunction

   function automatic void mat_product(input elem_type x [4], input elem_type y [4],
                                       output elem_type r [4], inout bit sat);
      r[0] = clip(round_prod(prod(x[0], y[0]) + prod(x[1], y[3])), sat);
      r[1] = clip(round_prod(prod(x[0], y[1]) + prod(x[1], y[2])), sat);
      r[2] = clip(round_prod(prod(x[3], y[1]) + prod(x[2], y[2])), sat);
      r[3] = clip(round_prod(prod(x[3], y[0]) + prod(x[2], y[3])), sat);
   endfunction

   function automatic mat_rsp_type predict_matrix_op(input mat_item_type it);
      mat_rsp_type o;
      elem_type t [4];
      bit sat;
      wide_type sa, sb, diff;
      sat = 1'b0;
      o.r = '{0, 0, 0, 0};
      o.status = STAT_OK;
      o.cmp = CMP_LESS;
      sa = 0;
      sb = 0;
      case (it.op)
         OP_ADD: for (int i = 0; i < 4; i++)
            o.r[i] = clip(wide_type'(it.a[i]) + it.b[i], sat);
         OP_SUB: for (int i = 0; i < 4; i++)
            o.r[i] = clip(wide_type'(it.a[i]) - it.b[i], sat);
         OP_MUL: mat_product(it.a, it.b, o.r, sat);
         OP_AINVB: begin
            if (invert(it.b, t, sat)) mat_product(it.a, t, o.r, sat);
            else o.status = STAT_SING;
         end
         OP_INV: if (!invert(it.a, o.r, sat)) o.status = STAT_SING;
         OP_ADDS: for (int i = 0; i < 4; i++)
            o.r[i] = clip(wide_type'(it.a[i]) + it.s, sat);
         OP_SUBS: for (int i = 0; i < 4; i++)
            o.r[i] = clip(wide_type'(it.a[i]) - it.s, sat);
         OP_MULS: for (int i = 0; i < 4; i++)
            o.r[i] = clip(round_prod(prod(it.a[i], it.s)), sat);
         OP_DIVS: begin
            if (it.s == 0) o.status = STAT_DIV0;
            else for (int i = 0; i < 4; i++)
               o.r[i] = fx_div(wide_type'(it.a[i]), wide_type'(it.s), sat);
         end
         OP_SSUB: for (int i = 0; i < 4; i++)
            o.r[i] = clip(wide_type'(it.s) - it.a[i], sat);
         OP_SINV: begin
            if (invert(it.a, t, sat)) begin
               for (int i = 0; i < 4; i++) o.r[i] = clip(round_prod(prod(it.s, t[i])), sat);
            end else begin
               o.status = STAT_SING;
            end
         end
         OP_ABS: for (int i = 0; i < 4; i++)
            o.r[i] = clip(it.a[i] < 0 ? -wide_type'(it.a[i]) : wide_type'(it.a[i]), sat);
         OP_NEG: for (int i = 0; i < 4; i++) o.r[i] = clip(-wide_type'(it.a[i]), sat);
         OP_CMP: begin
            for (int i = 0; i < 4; i++) begin
               sa += it.a[i] < 0 ? -wide_type'(it.a[i]) : wide_type'(it.a[i]);
               sb += it.b[i] < 0 ? -wide_type'(it.b[i]) : wide_type'(it.b[i]);
            end
            diff = sa - sb;
            if (diff < 0) diff = -diff;
            if (diff < wide_type'(eq_tol)) o.cmp = CMP_EQUAL;
            else if (sa < sb) o.cmp = CMP_LESS;
            else o.cmp = CMP_GREATER;
         end
         OP_MAX: begin
            o.r[0] = it.a[0];
            for (int i = 1; i < 4; i++) if (it.a[i] > o.r[0]) o.r[0] = it.a[i];
         end
         default: ;
      endcase
      if (o.status != STAT_OK) o.r = '{0, 0, 0, 0};
      else if (sat) o.status = STAT_SAT;
      return o;
   endfunction

   function automatic elem_type rand_elem();
      case ($urandom_range(0, 7))
         0, 1: return elem_type'($urandom);
         2: return elem_type'($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
         3: return elem_type'($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000;
         4: begin
            case ($urandom_range(0, 3))
               0: return MAXV;
               1: return MINV;
               2: return 0;
               default: return -ONE;
            endcase
         end
         5: return elem_type'(int'($urandom_range(0, 8)) - 4) * ONE;
         default: return elem_type'($urandom_range(0, 32'h0002_0000)) - ONE;
      endcase
   endfunction

   function automatic mat_item_type rand_item();
      mat_item_type it;
      int k;
      it.op = 4'($urandom_range(0, 15));
      for (int i = 0; i < 4; i++) begin
         it.a[i] = rand_elem();
         it.b[i] = rand_elem();
      end
      it.s = ($urandom_range(0, 9) == 0) ? elem_type'(0) : rand_elem();
      if (it.op == OP_CMP && $urandom_range(0, 1) == 1) begin
         k = $urandom_range(0, 3);
         for (int i = 0; i < 4; i++)
            it.b[i] = ($urandom_range(0, 1) == 1) ? it.a[(i + k) % 4] : -it.a[(i + k) % 4];
         it.b[k] = it.b[k] + elem_type'(int'($urandom_range(0, 1400)) - 700);
      end
      return it;
   endfunction

   task automatic send_item(input mat_item_type it, input bit known, input mat_rsp_type exp);
      req_valid <= 1'b1;
      req_type <= it.op;
      req_a_e1 <= it.a[0];
      req_a_e2 <= it.a[1];
      req_a_e3 <= it.a[2];
      req_a_e4 <= it.a[3];
      req_b_e1 <= it.b[0];
      req_b_e2 <= it.b[1];
      req_b_e3 <= it.b[2];
      req_b_e4 <= it.b[3];
      req_scalar_val <= it.s;
      do @(posedge clock); while (!req_ready);
      pending_rsp.push_back(known ? exp : predict_matrix_op(it));
      items_sent++;
      op_count[it.op]++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IW-1:0] idx, input logic [CFG_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_DET_THR) det_thr = val;
      else if (idx == CSR_EQ_TOL) eq_tol = val;
      @(posedge clock);
   endtask

   task automatic run_random(input int count);
      int burst;
      int gap;
      mat_rsp_type none;
      burst = $urandom_range(1, 20);
      none = '{r: '{0, 0, 0, 0}, status: STAT_OK, cmp: CMP_LESS};
      for (int n = 0; n < count; n++) begin
         send_item(rand_item(), 1'b0, none);
         burst--;
         if (burst == 0) begin
            burst = $urandom_range(1, 20);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
               req_valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
      end
      wait_drained();
   endtask

   always @(posedge clock) begin
      cyc <= cyc + 1;
      if (cyc % 150 == 0) stall_mode <= $urandom_range(0, 2);
      case (stall_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= 1'($urandom_range(0, 1));
         default: rsp_ready <= ($urandom_range(0, 3) == 0);
      endcase
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_seen++;
         if (pending_rsp.size() == 0) begin
            $display("%0t: unexpected result e1=%h status=%0d", $time, rsp_r_e1, rsp_status);
            errors++;
         end else begin
            automatic mat_rsp_type e = pending_rsp.pop_front();
            automatic elem_type got [4] = '{rsp_r_e1, rsp_r_e2, rsp_r_e3, rsp_r_e4};
            for (int i = 0; i < 4; i++) begin
               if (got[i] !== e.r[i]) begin
                  $display("%0t: r_e%0d expected %h actual %h", $time, i + 1, e.r[i], got[i]);
                  errors++;
               end
            end
            if (rsp_status !== e.status) begin
               $display("%0t: status expected %0d actual %0d", $time, e.status, rsp_status);
               errors++;
            end
            if (rsp_cmp_code !== e.cmp) begin
               $display("%0t: cmp_code expected %0d actual %0d", $time, e.cmp, rsp_cmp_code);
               errors++;
            end
         end
      end
   end

   initial begin
      #2ms;
      $display("matrix2x2_arith_unit_top_test: errors");
      $finish;
   end

   initial begin
      mat_rsp_type z;
      elem_type zq [4];
      elem_type id [4];
      z = '{r: '{0, 0, 0, 0}, status: STAT_OK, cmp: CMP_LESS};
      zq = '{0, 0, 0, 0};
      id = '{ONE, 0, ONE, 0};
      foreach (op_count[i]) op_count[i] = 0;

      dir_tab.push_back('{'{OP_ADD, zq, zq, 0}, 1, z});
      dir_tab.push_back('{'{OP_ADD, '{MAXV, MAXV, MAXV, MAXV}, '{MAXV, MAXV, MAXV, MAXV}, 0},
                         1, '{'{MAXV, MAXV, MAXV, MAXV}, STAT_SAT, CMP_LESS}});
      dir_tab.push_back('{'{OP_SUB, '{MINV, MINV, MINV, MINV}, '{MAXV, MAXV, MAXV, MAXV}, 0},
                         1, '{'{MINV, MINV, MINV, MINV}, STAT_SAT, CMP_LESS}});
      dir_tab.push_back('{'{OP_NEG, '{MINV, 0, 0, 0}, zq, 0},
                         1, '{'{MAXV, 0, 0, 0}, STAT_SAT, CMP_LESS}});
      dir_tab.push_back('{'{OP_ABS, '{MINV, -ONE, ONE, 0}, zq, 0},
                         1, '{'{MAXV, ONE, ONE, 0}, STAT_SAT, CMP_LESS}});
      dir_tab.push_back('{'{OP_DIVS, '{ONE, MAXV, MINV, 5}, zq, 0},
                         1, '{zq, STAT_DIV0, CMP_LESS}});
      dir_tab.push_back('{'{OP_INV, zq, zq, ONE}, 1, '{zq, STAT_SING, CMP_LESS}});
      dir_tab.push_back('{'{OP_AINVB, id, zq, ONE}, 1, '{zq, STAT_SING, CMP_LESS}});
      dir_tab.push_back('{'{OP_SINV, zq, id, ONE}, 1, '{zq, STAT_SING, CMP_LESS}});
      dir_tab.push_back('{'{OP_NONE, '{MAXV, MINV, 7, -7}, id, MAXV}, 1, z});
      dir_tab.push_back('{'{OP_MAX, '{-5, 7, MINV, MAXV}, zq, 0},
                         1, '{'{MAXV, 0, 0, 0}, STAT_OK, CMP_LESS}});
      dir_tab.push_back('{'{OP_CMP, id, id, 0}, 1, '{zq, STAT_OK, CMP_EQUAL}});
      dir_tab.push_back('{'{OP_CMP, id, '{MAXV, 0, 0, 0}, 0}, 1, '{zq, STAT_OK, CMP_LESS}});
      dir_tab.push_back('{'{OP_CMP, '{MINV, MINV, MINV, MINV}, id, 0},
                         1, '{zq, STAT_OK, CMP_GREATER}});
      dir_tab.push_back('{'{OP_INV, id, zq, 0}, 1, '{id, STAT_OK, CMP_LESS}});
      dir_tab.push_back('{'{OP_MUL, id, '{3, -ONE, MAXV, MINV}, 0}, 0, z});
      dir_tab.push_back('{'{OP_MUL, '{MAXV, MAXV, MAXV, MAXV}, '{MAXV, MAXV, MINV, MINV}, 0},
                         0, z});
      dir_tab.push_back('{'{OP_AINVB, '{ONE, 2 * ONE, 3 * ONE, 4 * ONE},
                            '{2 * ONE, ONE, 3 * ONE, ONE}, 0}, 0, z});
      dir_tab.push_back('{'{OP_ADDS, '{1, -1, MAXV, MINV}, zq, MINV}, 0, z});
      dir_tab.push_back('{'{OP_SUBS, '{1, -1, MAXV, MINV}, zq, MAXV}, 0, z});
      dir_tab.push_back('{'{OP_MULS, '{ONE, -ONE, MAXV, MINV}, zq, -ONE}, 0, z});
      dir_tab.push_back('{'{OP_DIVS, '{ONE, -3, MAXV, MINV}, zq, 3}, 0, z});
      dir_tab.push_back('{'{OP_SSUB, '{1, -1, MAXV, MINV}, zq, MINV}, 0, z});
      dir_tab.push_back('{'{OP_SINV, '{2 * ONE, 0, ONE / 2, 0}, zq, -3 * ONE}, 0, z});
      dir_tab.push_back('{'{OP_INV, '{1, 0, 1, 0}, zq, 0}, 0, z});

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_tab[i]) send_item(dir_tab[i].it, dir_tab[i].known, dir_tab[i].exp);
      wait_drained();
      run_random(300);

      write_reg(CSR_DET_THR, '0);
      write_reg(CSR_EQ_TOL, '0);
      run_random(280);

      write_reg(CSR_DET_THR, '1);
      write_reg(CSR_EQ_TOL, '1);
      run_random(200);

      write_reg(CSR_DET_THR, 31'($urandom_range(0, 32'h0004_0000)));
      write_reg(CSR_EQ_TOL, 31'($urandom_range(0, 32'h0010_0000)));
      write_reg(CSR_UNUSED, 31'($urandom));
      run_random(320);

      write_reg(CSR_DET_THR, 31'd1);
      write_reg(CSR_EQ_TOL, 31'd655);
      run_random(330);

      $display("Sent %0d items (%0d directed) over five register settings; %0d results checked.",
               items_sent, dir_tab.size(), rsp_seen);
      $display("Inverse-type items: %0d, compares: %0d, scalar divides: %0d.",
               op_count[OP_INV] + op_count[OP_AINVB] + op_count[OP_SINV],
               op_count[OP_CMP], op_count[OP_DIVS]);
      if (errors == 0 && pending_rsp.size() == 0) begin
         $display("matrix2x2_arith_unit_top_test: clean");
      end else begin
         $display("matrix2x2_arith_unit_top_test: errors");
      end
      $finish;
   end

endmodule
`default_nettype wire

[filelist.f]
hdl/m2x2_pkg.sv
hdl/m2x2_mul_lane.sv
hdl/m2x2_div_lane.sv
hdl/matrix2x2_arith_unit_top.sv
verif/matrix2x2_arith_unit_top_test.sv
